@@ hw/rtl/cdt_pkg.sv @@
// Shared types, constants and helper functions for the class distribution table.
// Used by the controller, the datapath, the top level and the port checker.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package cdt_pkg;

	// Table geometry and accumulator width
	localparam int NUM_BAGS    = 16;
	localparam int NUM_CLASSES = 8;
	localparam int ACC_WIDTH   = 40;

	localparam int BAG_W  = (NUM_BAGS > 1) ? $clog2(NUM_BAGS) : 1;
	localparam int CLS_W  = $clog2(NUM_CLASSES);
	localparam int CELLS  = NUM_BAGS * NUM_CLASSES;
	localparam int CELL_W = BAG_W + CLS_W;

	// One counter walks the classes (plus one read-latency slot), then the bags
	localparam int SCAN_MAX = (NUM_BAGS - 1 > NUM_CLASSES) ? NUM_BAGS - 1 : NUM_CLASSES;
	localparam int CNT_W    = $clog2(SCAN_MAX + 1);

	// Fixed field widths of the stream items
	localparam int BAG_IDX_W = 4;
	localparam int CLS_IDX_W = 3;
	localparam int ROWS_W    = 20;
	localparam int WEIGHT_W  = 16;
	localparam int MINOBJ_W  = 40;
	localparam int FIELD_W   = 40;
	localparam int PROD_W    = ROWS_W + WEIGHT_W;

	localparam int IN_DATA_W  = 32;
	localparam int OUT_BITS   = 3 + FIELD_W + FIELD_W + 3 + FIELD_W + FIELD_W + 4 + 1 + 1;
	localparam int OUT_DATA_W = ((OUT_BITS + 7) / 8) * 8;
	localparam int OUT_PAD_W  = OUT_DATA_W - OUT_BITS;

	// Configuration port
	localparam int CFG_ADDR_W = 1;
	localparam int CFG_DATA_W = 40;
	localparam logic [CFG_ADDR_W-1:0] REG_ROW_WEIGHT  = 1'd0;
	localparam logic [CFG_ADDR_W-1:0] REG_MIN_OBJECTS = 1'd1;
	localparam logic [WEIGHT_W-1:0]   ROW_WEIGHT_RST  = 16'd256;
	localparam logic [MINOBJ_W-1:0]   MIN_OBJECTS_RST = 40'd512;

	// Item operation codes (carried in tuser)
	localparam logic FUNC_ADD   = 1'b0;
	localparam logic FUNC_CLEAR = 1'b1;

	typedef logic [ACC_WIDTH-1:0] acc_t;
	localparam acc_t ACC_MAX = '1;

	typedef struct packed {
		logic ovf;
		acc_t val;
	} sat_t;

	// Controller to datapath commands
	typedef struct packed {
		logic accept;
		logic mult;
		logic update;
		logic scan_a;
		logic scan_b;
		logic result;
	} cmd_t;

	// Datapath to controller status
	typedef struct packed {
		logic a_last;
		logic b_last;
	} sts_t;

	// Saturating accumulate of a product into an accumulator
	function automatic sat_t sat_add(acc_t acc, logic [PROD_W-1:0] inc);
		logic [64:0] sum;
		sat_t        r;
		sum = 65'(acc) + 65'(inc);
		if (sum > 65'(ACC_MAX)) begin
			r.ovf = 1'b1;
			r.val = ACC_MAX;
		end else begin
			r.ovf = 1'b0;
			r.val = sum[ACC_WIDTH-1:0];
		end
		return r;
	endfunction

	// Difference clamped at zero
	function automatic acc_t sub_clamp(acc_t a, acc_t b);
		return (a >= b) ? acc_t'(a - b) : '0;
	endfunction

	// Fit an accumulator into a result field
	function automatic logic [FIELD_W-1:0] to_field(acc_t v);
		logic [63:0] w;
		w = 64'(v);
		return w[FIELD_W-1:0];
	endfunction

endpackage

`default_nettype wire

@@ hw/rtl/cdt_ctrl.sv @@
// Sequencing state machine of the class distribution table.
// Issues commands to cdt_dpath and owns the handshake state; uses cdt_pkg.
`timescale 1ns / 1ps
`default_nettype none

module cdt_ctrl (
	input  wire           clk,
	input  wire           arst_n,
	input  wire           s_tvalid,
	output logic          s_tready,
	output logic          m_tvalid,
	input  wire           m_tready,
	input  cdt_pkg::sts_t sts,
	output cdt_pkg::cmd_t cmd
);
	import cdt_pkg::*;

	typedef enum logic [5:0] {
		S_IDLE  = 6'b000001,
		S_MUL   = 6'b000010,
		S_UPD   = 6'b000100,
		S_SCANA = 6'b001000,
		S_SCANB = 6'b010000,
		S_DONE  = 6'b100000
	} state_t;

	state_t state_q, state_d;
	logic   out_valid_q;

	assign s_tready = (state_q == S_IDLE);
	assign m_tvalid = out_valid_q;

	// Next state and commands
	always_comb begin
		state_d = state_q;
		cmd     = '0;
		case (state_q)
			S_IDLE: begin
				if (s_tvalid) begin
					cmd.accept = 1'b1;
					state_d    = S_MUL;
				end
			end
			S_MUL: begin
				cmd.mult = 1'b1;
				state_d  = S_UPD;
			end
			S_UPD: begin
				cmd.update = 1'b1;
				state_d    = S_SCANA;
			end
			S_SCANA: begin
				cmd.scan_a = 1'b1;
				if (sts.a_last) state_d = S_SCANB;
			end
			S_SCANB: begin
				cmd.scan_b = 1'b1;
				if (sts.b_last) state_d = S_DONE;
			end
			S_DONE: begin
				if (!out_valid_q || m_tready) begin
					cmd.result = 1'b1;
					state_d    = S_IDLE;
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

	// State and output-valid registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cmd.result) out_valid_q <= 1'b1;
			else if (m_tready) out_valid_q <= 1'b0;
		end
	end

endmodule

`default_nettype wire

@@ hw/rtl/cdt_dpath.sv @@
// Datapath of the class distribution table: config registers, count memory,
// totals, scan accumulators and the result register. Uses cdt_pkg.
`timescale 1ns / 1ps
`default_nettype none

module cdt_dpath (
	input  wire                                  clk,
	input  wire                                  arst_n,
	input  wire                                  cfg_we,
	input  wire  [cdt_pkg::CFG_ADDR_W-1:0]       cfg_addr,
	input  wire  [cdt_pkg::CFG_DATA_W-1:0]       cfg_data,
	input  wire  [cdt_pkg::IN_DATA_W-1:0]        s_tdata,
	input  wire                                  s_tuser,
	input  cdt_pkg::cmd_t                        cmd,
	output cdt_pkg::sts_t                        sts,
	output logic [cdt_pkg::OUT_DATA_W-1:0]       res
);
	import cdt_pkg::*;

	// Configuration
	logic [WEIGHT_W-1:0] weight_q;
	logic [MINOBJ_W-1:0] minobj_q;

	// Latched item
	logic                func_q;
	logic [BAG_W-1:0]    bag_q;
	logic [CLS_W-1:0]    cls_q;
	logic [ROWS_W-1:0]   rows_q;
	logic [PROD_W-1:0]   prod_s1;

	// Count store with per-entry valid bits
	acc_t                mem_q [CELLS];
	logic [CELLS-1:0]    vld_q;
	logic [CELL_W-1:0]   rd_addr;
	logic                rd_req;
	acc_t                rd_data_s1;
	logic                rd_vld_s1;
	logic                rd_en_s1;
	logic [CLS_W-1:0]    rd_idx_s1;
	acc_t                cell_val;

	// Totals
	acc_t                bag_tot_q [NUM_BAGS];
	acc_t                cls_tot_q [NUM_CLASSES];
	acc_t                grand_q;
	logic                sat_q;
	logic [BAG_W-1:0]    bt_addr;
	logic [CLS_W-1:0]    ct_addr;
	acc_t                bt_rd;
	acc_t                ct_rd;

	// Scan state
	logic [CNT_W-1:0]    cnt_q;
	logic                cnt_in_cls;
	acc_t                obest_q, bbest_q, maxv_q;
	logic [CLS_W-1:0]    oidx_q, bidx_q;
	logic [BAG_W-1:0]    largest_q;
	logic [1:0]          nmin_q;

	sat_t                s_cell, s_bag, s_cls, s_grand;
	logic [CLS_W-1:0]    bmaj;

	assign cnt_in_cls = (cnt_q < CNT_W'(NUM_CLASSES));
	assign sts.a_last = (cnt_q == CNT_W'(NUM_CLASSES));
	assign sts.b_last = (cnt_q == CNT_W'(NUM_BAGS - 1));

	// Configuration writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			weight_q <= ROW_WEIGHT_RST;
			minobj_q <= MIN_OBJECTS_RST;
		end else if (cfg_we) begin
			case (cfg_addr)
				REG_ROW_WEIGHT:  weight_q <= cfg_data[WEIGHT_W-1:0];
				REG_MIN_OBJECTS: minobj_q <= cfg_data[MINOBJ_W-1:0];
				default: ;
			endcase
		end
	end

	// Latch the item and form the weighted count
	always_ff @(posedge clk) begin
		if (cmd.accept) begin
			func_q <= s_tuser;
			bag_q  <= s_tdata[BAG_W-1:0];
			cls_q  <= s_tdata[BAG_IDX_W +: CLS_W];
			rows_q <= s_tdata[BAG_IDX_W + CLS_IDX_W +: ROWS_W];
		end
		if (cmd.mult) prod_s1 <= PROD_W'(rows_q) * PROD_W'(weight_q);
	end

	// Memory read port: the addressed cell, then the bag's classes
	assign rd_req  = cmd.mult || (cmd.scan_a && cnt_in_cls);
	assign rd_addr = cmd.scan_a ? {bag_q, cnt_q[CLS_W-1:0]} : {bag_q, cls_q};

	always_ff @(posedge clk) begin
		if (rd_req) rd_data_s1 <= mem_q[rd_addr];
		if (cmd.update && func_q == FUNC_ADD) mem_q[{bag_q, cls_q}] <= s_cell.val;
	end

	assign cell_val = rd_vld_s1 ? rd_data_s1 : '0;

	// Totals read ports
	assign bt_addr = cmd.scan_b ? cnt_q[BAG_W-1:0] : bag_q;
	assign ct_addr = cmd.scan_a ? cnt_q[CLS_W-1:0] : cls_q;
	assign bt_rd   = bag_tot_q[bt_addr];
	assign ct_rd   = cls_tot_q[ct_addr];

	// Saturating updates
	assign s_cell  = sat_add(cell_val, prod_s1);
	assign s_bag   = sat_add(bt_rd, prod_s1);
	assign s_cls   = sat_add(ct_rd, prod_s1);
	assign s_grand = sat_add(grand_q, prod_s1);

	// Accumulator state: clear item or add item
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q     <= '0;
			bag_tot_q <= '{default: '0};
			cls_tot_q <= '{default: '0};
			grand_q   <= '0;
			sat_q     <= 1'b0;
			rd_vld_s1 <= 1'b0;
			rd_en_s1  <= 1'b0;
			cnt_q     <= '0;
		end else begin
			if (rd_req) rd_vld_s1 <= vld_q[rd_addr];
			rd_en_s1 <= cmd.scan_a && cnt_in_cls;
			if (cmd.update) begin
				if (func_q == FUNC_CLEAR) begin
					vld_q     <= '0;
					bag_tot_q <= '{default: '0};
					cls_tot_q <= '{default: '0};
					grand_q   <= '0;
					sat_q     <= 1'b0;
				end else begin
					vld_q[{bag_q, cls_q}] <= 1'b1;
					bag_tot_q[bag_q]      <= s_bag.val;
					cls_tot_q[cls_q]      <= s_cls.val;
					grand_q               <= s_grand.val;
					sat_q <= sat_q | s_cell.ovf | s_bag.ovf | s_cls.ovf | s_grand.ovf;
				end
			end
			// Scan counter
			if (cmd.update || (cmd.scan_a && sts.a_last)) cnt_q <= '0;
			else if (cmd.scan_a || cmd.scan_b) cnt_q <= cnt_q + 1'b1;
		end
	end

	// Scan accumulators: class maxima, then bag maximum and split count
	always_ff @(posedge clk) begin
		if (cmd.update) begin
			obest_q   <= '0;
			oidx_q    <= '0;
			bbest_q   <= '0;
			bidx_q    <= '0;
			maxv_q    <= '0;
			largest_q <= '0;
			nmin_q    <= '0;
		end
		if (cmd.scan_a && cnt_in_cls && ct_rd > obest_q) begin
			obest_q <= ct_rd;
			oidx_q  <= cnt_q[CLS_W-1:0];
		end
		if (rd_en_s1 && cell_val > bbest_q) begin
			bbest_q <= cell_val;
			bidx_q  <= rd_idx_s1;
		end
		if (cmd.scan_a) rd_idx_s1 <= cnt_q[CLS_W-1:0];
		if (cmd.scan_b) begin
			if (bt_rd >= maxv_q) begin
				maxv_q    <= bt_rd;
				largest_q <= cnt_q[BAG_W-1:0];
			end
			if (64'(bt_rd) >= 64'(minobj_q) && nmin_q != 2'd2) nmin_q <= nmin_q + 2'd1;
		end
	end

	// Empty bag reports the overall majority class; its counts are then zero
	assign bmaj = (bt_rd == '0) ? oidx_q : bidx_q;

	// Result register
	always_ff @(posedge clk) begin
		if (cmd.result) begin
			res <= {OUT_PAD_W'(0),
				sat_q,
				(nmin_q == 2'd2),
				4'(largest_q),
				to_field(sub_clamp(grand_q, obest_q)),
				to_field(obest_q),
				3'(oidx_q),
				to_field(sub_clamp(bt_rd, bbest_q)),
				to_field(bbest_q),
				3'(bmaj)};
		end
	end

endmodule

`default_nettype wire

@@ hw/rtl/class_distribution_table.sv @@
// Top level of the class distribution table: controller plus datapath.
// Depends on cdt_pkg, cdt_ctrl and cdt_dpath.
//
// Usage:
//   Input stream s_*: tuser selects add (0) or clear (1); tdata carries the bag,
//   class and row count. An add multiplies the row count by row_weight and adds
//   it, saturating, to the cell, bag, class and grand totals; a count of zero
//   only queries. Every item yields one result on m_* for the addressed bag.
//   Configuration: cfg_we with cfg_addr 0 (row_weight) or 1 (min_objects);
//   write only while no item is in flight.
//   Sequence from input transfer to m_tvalid: multiply, update, a walk over the
//   bag's classes (plus one read-latency slot) through the count memory read
//   port, a walk over the bag totals, then the load of the result register.
//   The next item is taken only in the idle state, once the previous item has
//   loaded the result register.
//   Reset clears all counts, totals and the saturation flag at once (per-cell
//   valid bits), and loads row_weight 256 and min_objects 512.
//   A stalled receiver holds the result in the output register; the next item
//   is accepted meanwhile and waits at its final step until the register frees.
`timescale 1ns / 1ps
`default_nettype none

module class_distribution_table (
	input  wire                               clk,
	input  wire                               arst_n,
	input  wire                               cfg_we,
	input  wire  [cdt_pkg::CFG_ADDR_W-1:0]    cfg_addr,
	input  wire  [cdt_pkg::CFG_DATA_W-1:0]    cfg_data,
	input  wire                               s_tvalid,
	output logic                              s_tready,
	// bag_index[3:0], class_index[6:4], row_count[26:7], zero pad
	input  wire  [cdt_pkg::IN_DATA_W-1:0]     s_tdata,
	// func[0]
	input  wire                               s_tuser,
	output logic                              m_tvalid,
	input  wire                               m_tready,
	// bag_major_class[2:0], bag_correct[42:3], bag_incorrect[82:43],
	// overall_major_class[85:83], overall_correct[125:86],
	// overall_incorrect[165:126], largest_bag[169:166], split_ok[170],
	// saturated[171], zero pad
	output logic [cdt_pkg::OUT_DATA_W-1:0]    m_tdata
);
	import cdt_pkg::*;

	cmd_t cmd;
	sts_t sts;

	cdt_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.sts      (sts),
		.cmd      (cmd)
	);

	cdt_dpath u_dpath (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg_we   (cfg_we),
		.cfg_addr (cfg_addr),
		.cfg_data (cfg_data),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.cmd      (cmd),
		.sts      (sts),
		.res      (m_tdata)
	);

endmodule

`default_nettype wire

@@ hw/rtl/cdt_checker.sv @@
// Port-level checker for class_distribution_table, bound to the top level.
// Depends on cdt_pkg.
`timescale 1ns / 1ps
`default_nettype none

module cdt_checker (
	input wire                            clk,
	input wire                            arst_n,
	input wire                            s_tvalid,
	input wire                            s_tready,
	input wire                            m_tvalid,
	input wire                            m_tready,
	input wire [cdt_pkg::OUT_DATA_W-1:0]  m_tdata
);
	import cdt_pkg::*;

	logic       s_xfer, m_xfer;
	logic [1:0] pend_q;

	assign s_xfer = s_tvalid && s_tready;
	assign m_xfer = m_tvalid && m_tready;

	// Track items taken in but not yet delivered
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pend_q <= '0;
		end else begin
			pend_q <= pend_q + {1'b0, s_xfer} - {1'b0, m_xfer};
		end
	end

	a_one_in_flight: assert property (@(posedge clk) disable iff (!arst_n)
		s_xfer |=> !s_tready)
		else $error("input accepted while an item is in work");

	a_no_phantom: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> pend_q != 2'd0)
		else $error("result shown without an accepted item");

	a_bounded: assert property (@(posedge clk) disable iff (!arst_n)
		pend_q != 2'd3)
		else $error("more than two items outstanding");

	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
		else $error("stalled result changed");

endmodule

bind class_distribution_table cdt_checker u_cdt_checker (
	.clk      (clk),
	.arst_n   (arst_n),
	.s_tvalid (s_tvalid),
	.s_tready (s_tready),
	.m_tvalid (m_tvalid),
	.m_tready (m_tready),
	.m_tdata  (m_tdata)
);

`default_nettype wire

@@ test/class_distribution_table_tb.sv @@
// Self-checking testbench for class_distribution_table: random and directed add/clear items
// are checked against a built-in model of the weighted contingency table.
// Depends on cdt_pkg and the class_distribution_table RTL.
`timescale 1ns / 1ps

module class_distribution_table_tb;
	import cdt_pkg::*;

	typedef struct {
		logic        func;
		logic [3:0]  bag;
		logic [2:0]  cls;
		logic [19:0] rows;
	} table_item_t;

	typedef struct {
		logic [2:0]  bag_major;
		logic [39:0] bag_correct;
		logic [39:0] bag_incorrect;
		logic [2:0]  overall_major;
		logic [39:0] overall_correct;
		logic [39:0] overall_incorrect;
		logic [3:0]  largest_bag;
		logic        split_ok;
		logic        saturated;
	} bag_report_t;

	logic                  clk = 1'b0;
	logic                  arst_n = 1'b0;
	logic                  cfg_we = 1'b0;
	logic [CFG_ADDR_W-1:0] cfg_addr = '0;
	logic [CFG_DATA_W-1:0] cfg_data = '0;
	logic                  s_tvalid = 1'b0;
	logic                  s_tready;
	// bag_index[3:0], class_index[6:4], row_count[26:7], zero pad
	logic [IN_DATA_W-1:0]  s_tdata = '0;
	// func[0]
	logic                  s_tuser = 1'b0;
	logic                  m_tvalid;
	logic                  m_tready = 1'b0;
	// bag_major_class[2:0], bag_correct[42:3], bag_incorrect[82:43],
	// overall_major_class[85:83], overall_correct[125:86],
	// overall_incorrect[165:126], largest_bag[169:166], split_ok[170], saturated[171]
	logic [OUT_DATA_W-1:0] m_tdata;

	class_distribution_table dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg_we   (cfg_we),
		.cfg_addr (cfg_addr),
		.cfg_data (cfg_data),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata)
	);

	always #4 clk = ~clk;

	// Model state: weighted counts, totals and configuration shadow
	logic [39:0] cell_cnt [NUM_BAGS*NUM_CLASSES] = '{default: '0};
	logic [39:0] bag_sum [NUM_BAGS] = '{default: '0};
	logic [39:0] class_sum [NUM_CLASSES] = '{default: '0};
	logic [39:0] grand_sum = '0;
	logic        sat_seen = 1'b0;
	logic [15:0] weight_shadow = ROW_WEIGHT_RST;
	logic [39:0] min_obj_shadow = MIN_OBJECTS_RST;

	table_item_t item_backlog [$];
	bag_report_t reports_due [$];
	int          mismatch_cnt = 0;
	int          src_gap = 0;
	int          snk_gap = 0;
	bit          steady = 1'b0;

	task automatic report_mismatch(input string what, input logic [39:0] got,
			input logic [39:0] want);
		// keep the log bounded if the block is badly broken
		if (mismatch_cnt < 200)
			$display("%0t ns: %s: got %0h, want %0h", $realtime, what, got, want);
		mismatch_cnt++;
	endtask

	// Gap lengths: mostly none, some short, a few long
	function automatic int pick_gap();
		int r;
		r = $urandom_range(0, 99);
		if (steady || r < 55)
			return 0;
		if (r < 92)
			return $urandom_range(1, 3);
		return $urandom_range(8, 40);
	endfunction

	// Saturating add into a 40-bit accumulator; flags an overflow
	function automatic logic [39:0] sat_sum(input logic [39:0] acc, input logic [35:0] inc);
		logic [40:0] s;
		s = {1'b0, acc} + {5'b0, inc};
		if (s[40]) begin
			sat_seen = 1'b1;
			return '1;
		end
		return s[39:0];
	endfunction

	function automatic logic [2:0] overall_leader();
		logic [39:0] best;
		logic [2:0]  idx;
		best = '0;
		idx = '0;
		for (int c = 0; c < NUM_CLASSES; c++)
			if (class_sum[c] > best) begin
				best = class_sum[c];
				idx = c[2:0];
			end
		return idx;
	endfunction

	// Apply one item to the table and queue the report it produces
	task automatic tally_item(input table_item_t it);
		logic [35:0] prod;
		logic [39:0] best;
		logic [39:0] top;
		int          slot;
		int          hits;
		bag_report_t r;
		slot = it.bag * NUM_CLASSES + it.cls;
		if (it.func == FUNC_CLEAR) begin
			foreach (cell_cnt[i]) cell_cnt[i] = '0;
			foreach (bag_sum[i]) bag_sum[i] = '0;
			foreach (class_sum[i]) class_sum[i] = '0;
			grand_sum = '0;
			sat_seen = 1'b0;
		end else begin
			prod = it.rows * weight_shadow;
			cell_cnt[slot] = sat_sum(cell_cnt[slot], prod);
			bag_sum[it.bag] = sat_sum(bag_sum[it.bag], prod);
			class_sum[it.cls] = sat_sum(class_sum[it.cls], prod);
			grand_sum = sat_sum(grand_sum, prod);
		end

		// bag majority, falling back to the overall leader for an empty bag
		if (bag_sum[it.bag] == 0) begin
			r.bag_major = overall_leader();
		end else begin
			best = '0;
			r.bag_major = '0;
			for (int c = 0; c < NUM_CLASSES; c++)
				if (cell_cnt[it.bag*NUM_CLASSES + c] > best) begin
					best = cell_cnt[it.bag*NUM_CLASSES + c];
					r.bag_major = c[2:0];
				end
		end
		r.bag_correct = cell_cnt[it.bag*NUM_CLASSES + r.bag_major];
		r.bag_incorrect = (bag_sum[it.bag] >= r.bag_correct) ?
			bag_sum[it.bag] - r.bag_correct : '0;

		r.overall_major = overall_leader();
		r.overall_correct = class_sum[r.overall_major];
		r.overall_incorrect = (grand_sum >= r.overall_correct) ?
			grand_sum - r.overall_correct : '0;

		// largest bag keeps the last tie; count bags reaching the minimum
		top = '0;
		hits = 0;
		r.largest_bag = '0;
		for (int b = 0; b < NUM_BAGS; b++) begin
			if (bag_sum[b] >= top) begin
				top = bag_sum[b];
				r.largest_bag = b[3:0];
			end
			if (bag_sum[b] >= min_obj_shadow)
				hits++;
		end
		r.split_ok = (hits > 1);
		r.saturated = sat_seen;
		reports_due.push_back(r);
	endtask

	// Driver: present backlog items, record each transfer in the model
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s_tvalid <= 1'b0;
			s_tdata <= '0;
			s_tuser <= 1'b0;
			src_gap <= 0;
		end else begin
			if (s_tvalid && s_tready)
				tally_item('{func: s_tuser, bag: s_tdata[3:0], cls: s_tdata[6:4],
					rows: s_tdata[26:7]});
			if (!s_tvalid || s_tready) begin
				if (src_gap > 0) begin
					src_gap <= src_gap - 1;
					s_tvalid <= 1'b0;
				end else if (item_backlog.size() > 0) begin
					table_item_t nx;
					nx = item_backlog.pop_front();
					s_tvalid <= 1'b1;
					s_tuser <= nx.func;
					s_tdata <= IN_DATA_W'({nx.rows, nx.cls, nx.bag});
					src_gap <= pick_gap();
				end else begin
					s_tvalid <= 1'b0;
				end
			end
		end
	end

	// Monitor: random backpressure, compare each result transfer with the oldest report
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tready <= 1'b0;
			snk_gap <= 0;
		end else begin
			if (m_tvalid && m_tready) begin
				if (reports_due.size() == 0) begin
					report_mismatch("result with none expected", m_tdata[42:3], '0);
				end else begin
					bag_report_t w;
					w = reports_due.pop_front();
					if (m_tdata[2:0] !== w.bag_major)
						report_mismatch("bag_major_class", m_tdata[2:0], w.bag_major);
					if (m_tdata[42:3] !== w.bag_correct)
						report_mismatch("bag_correct", m_tdata[42:3], w.bag_correct);
					if (m_tdata[82:43] !== w.bag_incorrect)
						report_mismatch("bag_incorrect", m_tdata[82:43], w.bag_incorrect);
					if (m_tdata[85:83] !== w.overall_major)
						report_mismatch("overall_major_class", m_tdata[85:83],
							w.overall_major);
					if (m_tdata[125:86] !== w.overall_correct)
						report_mismatch("overall_correct", m_tdata[125:86],
							w.overall_correct);
					if (m_tdata[165:126] !== w.overall_incorrect)
						report_mismatch("overall_incorrect", m_tdata[165:126],
							w.overall_incorrect);
					if (m_tdata[169:166] !== w.largest_bag)
						report_mismatch("largest_bag", m_tdata[169:166], w.largest_bag);
					if (m_tdata[170] !== w.split_ok)
						report_mismatch("split_ok", m_tdata[170], w.split_ok);
					if (m_tdata[171] !== w.saturated)
						report_mismatch("saturated", m_tdata[171], w.saturated);
				end
			end
			if (snk_gap > 0) begin
				m_tready <= 1'b0;
				snk_gap <= snk_gap - 1;
			end else begin
				m_tready <= 1'b1;
				if ((m_tvalid && m_tready) || $urandom_range(0, 15) == 0)
					snk_gap <= pick_gap();
			end
		end
	end

	// Hold until the backlog is drained and every report has arrived, then let the pipe settle
	task automatic wait_drained();
		do
			@(posedge clk);
		while (item_backlog.size() != 0 || s_tvalid || reports_due.size() != 0);
		repeat (40) @(posedge clk);
	endtask

	task automatic write_reg(input logic [CFG_ADDR_W-1:0] idx, input logic [39:0] val);
		@(posedge clk);
		cfg_we <= 1'b1;
		cfg_addr <= idx;
		cfg_data <= val;
		@(posedge clk);
		cfg_we <= 1'b0;
		if (idx == REG_ROW_WEIGHT)
			weight_shadow = val[15:0];
		else
			min_obj_shadow = val;
	endtask

	function automatic table_item_t random_item(input int bag_hi);
		table_item_t it;
		int          r;
		it.func = ($urandom_range(0, 49) == 0) ? FUNC_CLEAR : FUNC_ADD;
		it.bag = 4'($urandom_range(0, bag_hi));
		it.cls = 3'($urandom_range(0, 7));
		r = $urandom_range(0, 9);
		if (r == 0)
			it.rows = '0;
		else if (r == 1)
			it.rows = '1;
		else if (r < 6)
			it.rows = 20'($urandom_range(1, 255));
		else
			it.rows = 20'($urandom);
		return it;
	endfunction

	// Stimulus: directed checks, then random phases under varied settings
	initial begin
		logic [15:0] wt_plan [6];
		logic [39:0] mo_plan [6];
		wt_plan = '{16'd256, 16'd0, 16'hFFFF, 16'd1, 16'($urandom),
			16'($urandom_range(1, 1023))};
		mo_plan = '{40'd512, {8'($urandom), 32'($urandom)}, 40'd0, '1,
			40'({$urandom_range(0, 255), 32'($urandom)}), 40'($urandom_range(0, 1 << 20))};

		repeat (9) @(posedge clk);
		arst_n <= 1'b1;

		// query an empty table, ties within a bag, empty bag, clear
		item_backlog.push_back('{FUNC_ADD, 4'd0, 3'd0, 20'd0});
		item_backlog.push_back('{FUNC_ADD, 4'd15, 3'd7, 20'hFFFFF});
		item_backlog.push_back('{FUNC_ADD, 4'd5, 3'd3, 20'd1});
		item_backlog.push_back('{FUNC_ADD, 4'd5, 3'd6, 20'd1});
		item_backlog.push_back('{FUNC_ADD, 4'd9, 3'd2, 20'd0});
		item_backlog.push_back('{FUNC_CLEAR, 4'd9, 3'd2, 20'd0});
		wait_drained();

		// drive one cell into saturation at the largest weight, then clear
		write_reg(REG_ROW_WEIGHT, 40'hFFFF);
		for (int i = 0; i < 17; i++)
			item_backlog.push_back('{FUNC_ADD, 4'd0, 3'd0, 20'hFFFFF});
		item_backlog.push_back('{FUNC_ADD, 4'd10, 3'd4, 20'd0});
		item_backlog.push_back('{FUNC_CLEAR, 4'd0, 3'd0, 20'd0});
		wait_drained();

		for (int ph = 0; ph < 6; ph++) begin
			int bag_hi;
			write_reg(REG_ROW_WEIGHT, 40'(wt_plan[ph]));
			write_reg(REG_MIN_OBJECTS, mo_plan[ph]);
			steady = (ph == 2);
			bag_hi = (ph == 3) ? 3 : 15;
			for (int i = 0; i < 165; i++)
				item_backlog.push_back(random_item(bag_hi));
			wait_drained();
		end

		if (mismatch_cnt == 0)
			$display("end of test: clean");
		else
			$display("end of test: mismatches");
		$finish;
	end

	// Watchdog
	initial begin
		#8_000_000;
		$display("end of test: mismatches");
		$finish;
	end

endmodule
